// ===== hw/rtl/wbss_pkg.sv =====
// Package for the wildcard byte stream search block.
// Holds widths, register indexes, byte codes and byte classification helpers.
// No dependencies.
package wbss_pkg;

  // Default depth of the candidate shift register (longest usable pattern).
  localparam int MAX_PATTERN_DEF = 16;

  // Pattern bytes held in the two 64-bit pattern registers.
  localparam int PAT_BYTES = 16;

  // Configuration port geometry: 64-bit registers at byte address 8*i.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;
  localparam int LEN_W      = 5;

  // Width of stream offsets and counters.
  localparam int CNT_W = 32;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_PAT_LOW    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAT_HIGH   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PAT_LEN    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_IGN_CASE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WILDCARD   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_WHOLE_WORD = 3'd5;

  // Byte codes.
  localparam logic [7:0] NEWLINE_BYTE  = 8'd10;
  localparam logic [7:0] WILDCARD_BYTE = 8'h3F;

  // A word byte is an ASCII letter, a digit or an underscore.
  function automatic logic is_word(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h30) && (c <= 8'h39)) || (c == 8'h5F);
  endfunction

  // Fold a lower case letter to upper case.
  function automatic logic [7:0] fold_upper(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'd32) : c;
  endfunction

endpackage

// ===== hw/rtl/wbss_if.sv =====
// Stream channel interfaces of the wildcard byte stream search block.
// One interface for the byte requests and one for the search results.
// No dependencies.
interface wbss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_search;
  logic       end_of_data;

  modport source (output valid, data_byte, start_of_search, end_of_data, input ready);
  modport sink   (input valid, data_byte, start_of_search, end_of_data, output ready);
endinterface

interface wbss_out_if;
  logic        valid;
  logic        ready;
  logic        match_found;
  logic [31:0] match_start;
  logic [31:0] lines_seen;
  logic [31:0] line_start;
  logic        no_match;

  modport source (output valid, match_found, match_start, lines_seen, line_start, no_match,
                  input ready);
  modport sink   (input valid, match_found, match_start, lines_seen, line_start, no_match,
                  output ready);
endinterface

// ===== hw/rtl/wildcard_byte_stream_search.sv =====
// Top level of the wildcard byte stream search block.
// Depends on wbss_pkg and the channel interfaces in wbss_if.sv.
//
// Usage:
//   Bytes arrive on in_i (valid/ready), one request per byte, with
//   start_of_search on the first byte of a search and end_of_data on the last.
//   Every accepted byte yields exactly one result on out_o: match_found with
//   match_start on the request that confirms the first match, no_match on the
//   last byte of a stream without a match, and the newline count and the
//   offset of the current line with every result.
//   The pattern and options are written over the APB port (64-bit registers
//   at byte address 8*i) while no byte is in flight.
//   An accepted byte passes the input register, then the result register.
//   Throughput is one byte per cycle while the receiver takes results: all
//   alignments advance in one shift of the candidate register, which is the
//   loop between the input register and the result register.
//   In whole-word mode a match is confirmed one byte later, on the lookahead, unless its last byte ends the data.
//   Reset restores the default configuration (length 1, all else zero) and
//   clears all search state. When the receiver stalls, the result holds, the
//   input register takes one more byte, and then in_i.ready drops.
module wildcard_byte_stream_search #(
  parameter int MAX_PATTERN = wbss_pkg::MAX_PATTERN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wbss_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [wbss_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [wbss_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  wbss_in_if.sink                         in_i,
  wbss_out_if.source                      out_o
);

  localparam int LenW     = $clog2(MAX_PATTERN + 1);
  localparam int PadBytes = (MAX_PATTERN > wbss_pkg::PAT_BYTES) ? MAX_PATTERN
                                                                 : wbss_pkg::PAT_BYTES;
  localparam int CntW     = wbss_pkg::CNT_W;

  // Configuration registers.
  logic [63:0]                  pat_low_q, pat_high_q;
  logic [wbss_pkg::LEN_W-1:0]   pat_len_q;
  logic                         ign_case_q, wildcard_q, whole_word_q;
  logic [wbss_pkg::REG_IDX_W-1:0] reg_idx;
  logic                         cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[wbss_pkg::CFG_ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q    <= '0;
      pat_high_q   <= '0;
      pat_len_q    <= wbss_pkg::LEN_W'(1);
      ign_case_q   <= 1'b0;
      wildcard_q   <= 1'b0;
      whole_word_q <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        wbss_pkg::REG_PAT_LOW:    pat_low_q    <= pwdata;
        wbss_pkg::REG_PAT_HIGH:   pat_high_q   <= pwdata;
        wbss_pkg::REG_PAT_LEN:    pat_len_q    <= pwdata[wbss_pkg::LEN_W-1:0];
        wbss_pkg::REG_IGN_CASE:   ign_case_q   <= pwdata[0];
        wbss_pkg::REG_WILDCARD:   wildcard_q   <= pwdata[0];
        wbss_pkg::REG_WHOLE_WORD: whole_word_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      wbss_pkg::REG_PAT_LOW:    prdata = pat_low_q;
      wbss_pkg::REG_PAT_HIGH:   prdata = pat_high_q;
      wbss_pkg::REG_PAT_LEN:    prdata = wbss_pkg::CFG_DATA_W'(pat_len_q);
      wbss_pkg::REG_IGN_CASE:   prdata = wbss_pkg::CFG_DATA_W'(ign_case_q);
      wbss_pkg::REG_WILDCARD:   prdata = wbss_pkg::CFG_DATA_W'(wildcard_q);
      wbss_pkg::REG_WHOLE_WORD: prdata = wbss_pkg::CFG_DATA_W'(whole_word_q);
      default:                  prdata = '0;
    endcase
  end

  // Input register: holds one request while the result register is full.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_sos_q, s1_eod_q;
  logic       in_acc, advance;
  logic       out_valid_q;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= in_i.data_byte;
      s1_sos_q  <= in_i.start_of_search;
      s1_eod_q  <= in_i.end_of_data;
    end
  end

  // Search state.
  logic [MAX_PATTERN-1:0] alive_q, alive_d;
  logic [7:0]             prev_q, prev_d;
  logic [CntW-1:0]        pos_q, pos_d, nl_q, nl_d, lso_q, lso_d, pstart_q, pstart_d;
  logic                   pend_q, pend_d, done_q, done_d;

  // State as seen by this byte, after an optional start-of-search clear.
  logic [MAX_PATTERN-1:0] cur_alive;
  logic [7:0]             cur_prev;
  logic [CntW-1:0]        cur_pos, cur_nl, cur_lso, cur_pstart;
  logic                   cur_pend, cur_done;

  assign cur_alive  = s1_sos_q ? '0 : alive_q;
  assign cur_prev   = s1_sos_q ? '0 : prev_q;
  assign cur_pos    = s1_sos_q ? '0 : pos_q;
  assign cur_nl     = s1_sos_q ? '0 : nl_q;
  assign cur_lso    = s1_sos_q ? '0 : lso_q;
  assign cur_pstart = s1_sos_q ? '0 : pstart_q;
  assign cur_pend   = s1_sos_q ? 1'b0 : pend_q;
  assign cur_done   = s1_sos_q ? 1'b0 : done_q;

  // Effective pattern length, saturated at the candidate depth.
  logic [LenW-1:0]         len_eff;
  logic [8*PadBytes-1:0]   pat_all;
  logic [7:0]              mc;

  assign len_eff = (CntW'(pat_len_q) > CntW'(MAX_PATTERN)) ? LenW'(MAX_PATTERN)
                                                           : LenW'(pat_len_q);
  assign pat_all = (8*PadBytes)'({pat_high_q, pat_low_q});
  assign mc      = ign_case_q ? wbss_pkg::fold_upper(s1_byte_q) : s1_byte_q;

  // Candidate shift: every alignment advances by one byte in parallel.
  logic [MAX_PATTERN-1:0] raw_alive, next_alive;
  logic                   complete;

  always_comb begin
    logic [7:0] p;
    logic       m;
    complete = 1'b0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      p = pat_all[8*k +: 8];
      m = (wildcard_q && (p == wbss_pkg::WILDCARD_BYTE)) || (p == mc);
      if (k == 0) begin
        raw_alive[k] = m && (!whole_word_q || !wbss_pkg::is_word(cur_prev));
      end else begin
        raw_alive[k] = cur_alive[k-1] && m;
      end
      next_alive[k] = raw_alive[k] && ((k + 1) < int'(len_eff));
      if ((k + 1) == int'(len_eff)) begin
        complete = raw_alive[k];
      end
    end
  end

  // Next state and result for the byte in the input register.
  logic            res_found, res_none;
  logic [CntW-1:0] res_start, start_calc;

  assign start_calc = cur_pos - CntW'(len_eff) + CntW'(1);

  always_comb begin
    alive_d   = cur_alive;
    prev_d    = cur_prev;
    pos_d     = cur_pos;
    nl_d      = cur_nl;
    lso_d     = cur_lso;
    pend_d    = cur_pend;
    pstart_d  = cur_pstart;
    done_d    = cur_done;
    res_found = 1'b0;
    res_start = '0;
    res_none  = 1'b0;
    if (!cur_done) begin
      pend_d = 1'b0;
      if (cur_pend && !wbss_pkg::is_word(s1_byte_q)) begin
        // Lookahead byte is a boundary: the pending match is confirmed.
        done_d    = 1'b1;
        res_found = 1'b1;
        res_start = cur_pstart;
      end else begin
        if (mc == wbss_pkg::NEWLINE_BYTE) begin
          nl_d  = cur_nl + CntW'(1);
          lso_d = cur_pos + CntW'(1);
        end
        alive_d = next_alive;
        if (complete && (!whole_word_q || s1_eod_q)) begin
          done_d    = 1'b1;
          res_found = 1'b1;
          res_start = start_calc;
        end else begin
          if (complete) begin
            pend_d   = 1'b1;
            pstart_d = start_calc;
          end
          prev_d = s1_byte_q;
          pos_d  = cur_pos + CntW'(1);
          if (s1_eod_q) begin
            pend_d   = 1'b0;
            done_d   = 1'b1;
            res_none = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q  <= '0;
      prev_q   <= '0;
      pos_q    <= '0;
      nl_q     <= '0;
      lso_q    <= '0;
      pend_q   <= 1'b0;
      pstart_q <= '0;
      done_q   <= 1'b0;
    end else if (advance) begin
      alive_q  <= alive_d;
      prev_q   <= prev_d;
      pos_q    <= pos_d;
      nl_q     <= nl_d;
      lso_q    <= lso_d;
      pend_q   <= pend_d;
      pstart_q <= pstart_d;
      done_q   <= done_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_o.match_found <= res_found;
      out_o.match_start <= res_start;
      out_o.lines_seen  <= nl_d;
      out_o.line_start  <= lso_d;
      out_o.no_match    <= res_none;
    end
  end

  assign out_o.valid = out_valid_q;

`ifndef SYNTHESIS
  // A result never reports both a match and the absence of one.
  a_found_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.match_found && out_o.no_match))
    else $error("match_found and no_match both set");

  // The start offset is zero on results without a match.
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.match_found) |-> (out_o.match_start == '0))
    else $error("match_start nonzero without a match");

  // A confirmed match puts the search into its quiet state.
  a_quiet_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_found) |=> done_q)
    else $error("search not quiet after a match");

  // A match waiting for its lookahead byte never coexists with a finished search.
  a_pend_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_q && done_q))
    else $error("pending match in a finished search");
`endif

endmodule

// ===== tb/wbss_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the wildcard byte stream search testbench: a predictor of the
// search state and a queue of the results expected from the block.
// Depends on wbss_pkg for widths, register indexes and byte codes.
package wbss_tb_pkg;
  import wbss_pkg::*;

  // One search result as seen on the result channel.
  typedef struct packed {
    logic             match_found;
    logic [CNT_W-1:0] match_start;
    logic [CNT_W-1:0] lines_seen;
    logic [CNT_W-1:0] line_start;
    logic             no_match;
  } search_report_t;

  class search_scoreboard;
    // Configuration as last written over the register port.
    logic [63:0]      pat_low;
    logic [63:0]      pat_high;
    logic [LEN_W-1:0] pat_len;
    bit               fold_case;
    bit               wild_on;
    bit               words_only;

    // Search state.
    bit               alive [MAX_PATTERN_DEF];
    logic [7:0]       prev_byte;
    logic [CNT_W-1:0] offset;
    logic [CNT_W-1:0] newlines;
    logic [CNT_W-1:0] line_offset;
    logic [CNT_W-1:0] pending_offset;
    bit               pending;
    bit               finished;

    search_report_t   expected_reports[$];
    int unsigned      mismatches;
    int unsigned      reports_checked;
    int unsigned      matches_seen;
    int unsigned      misses_seen;
    int unsigned      bytes_scanned;

    function new();
      pat_low    = '0;
      pat_high   = '0;
      pat_len    = LEN_W'(1);
      fold_case  = 1'b0;
      wild_on    = 1'b0;
      words_only = 1'b0;
      clear_search();
    endfunction

    function void clear_search();
      foreach (alive[k]) alive[k] = 1'b0;
      prev_byte      = '0;
      offset         = '0;
      newlines       = '0;
      line_offset    = '0;
      pending_offset = '0;
      pending        = 1'b0;
      finished       = 1'b0;
    endfunction

    function void note_config(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
      case (idx)
        REG_PAT_LOW:    pat_low    = value;
        REG_PAT_HIGH:   pat_high   = value;
        REG_PAT_LEN:    pat_len    = value[LEN_W-1:0];
        REG_IGN_CASE:   fold_case  = value[0];
        REG_WILDCARD:   wild_on    = value[0];
        REG_WHOLE_WORD: words_only = value[0];
        default: ;
      endcase
    endfunction

    // Letters, digits and the underscore make up words.
    static function bit word_char(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || (c == "_");
    endfunction

    function logic [7:0] pattern_byte(int k);
      if (k < 8) return pat_low[8*k +: 8];
      if (k < 16) return pat_high[8*(k-8) +: 8];
      return '0;
    endfunction

    function bit pattern_hits(int k, logic [7:0] c);
      logic [7:0] p;
      p = pattern_byte(k);
      return (wild_on && p == WILDCARD_BYTE) || (p == c);
    endfunction

    function void push_report(bit found, logic [CNT_W-1:0] at, bit none);
      search_report_t r;
      r.match_found = found;
      r.match_start = found ? at : '0;
      r.lines_seen  = newlines;
      r.line_start  = line_offset;
      r.no_match    = none;
      expected_reports.push_back(r);
      if (found) matches_seen++;
      if (none) misses_seen++;
    endfunction

    // Advance the search by one accepted byte and queue the result it causes.
    function void note_byte(logic [7:0] c, bit sos, bit eod);
      logic [7:0]       folded;
      int               len;
      bit               complete;
      logic [CNT_W-1:0] first;
      if (sos) clear_search();
      if (finished) begin
        push_report(1'b0, '0, 1'b0);
        return;
      end
      bytes_scanned++;
      folded = (fold_case && c >= "a" && c <= "z") ? c - 8'd32 : c;
      len = (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pat_len);

      // A match that ended on the previous byte is confirmed by a non-word byte.
      if (pending) begin
        pending = 1'b0;
        if (!word_char(c)) begin
          finished = 1'b1;
          push_report(1'b1, pending_offset, 1'b0);
          return;
        end
      end

      if (folded == NEWLINE_BYTE) begin
        newlines++;
        line_offset = offset + 1;
      end

      // Shift every live alignment by one byte.
      complete = 1'b0;
      if (len > 0) begin
        for (int k = len - 1; k > 0; k--)
          alive[k] = alive[k-1] && pattern_hits(k, folded);
        alive[0] = pattern_hits(0, folded) && (!words_only || !word_char(prev_byte));
        complete = alive[len-1];
        alive[len-1] = 1'b0;
      end
      for (int k = len; k < MAX_PATTERN_DEF; k++) alive[k] = 1'b0;

      if (complete) begin
        first = offset - CNT_W'(len - 1);
        if (!words_only || eod) begin
          finished = 1'b1;
          push_report(1'b1, first, 1'b0);
          return;
        end
        pending        = 1'b1;
        pending_offset = first;
      end

      prev_byte = c;
      offset++;

      if (eod) begin
        pending  = 1'b0;
        finished = 1'b1;
        push_report(1'b0, '0, 1'b1);
        return;
      end
      push_report(1'b0, '0, 1'b0);
    endfunction

    function void compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_report(search_report_t got);
      search_report_t want;
      if (expected_reports.size() == 0) begin
        $error("search result arrived with no request outstanding");
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      reports_checked++;
      compare_field("match_found", want.match_found, got.match_found);
      compare_field("match_start", want.match_start, got.match_start);
      compare_field("lines_seen", want.lines_seen, got.lines_seen);
      compare_field("line_start", want.line_start, got.line_start);
      compare_field("no_match", want.no_match, got.no_match);
    endfunction

    function int outstanding();
      return expected_reports.size();
    endfunction
  endclass

endpackage

// ===== tb/tb_wildcard_byte_stream_search.sv =====
`timescale 1ns / 1ps
// Testbench top for the wildcard byte stream search block: directed cases,
// then random streams under many settings, with random stalls on both channels.
// Depends on wbss_pkg, wbss_if.sv, the block itself and wbss_tb_pkg.
module tb_wildcard_byte_stream_search;
  import wbss_pkg::*;
  import wbss_tb_pkg::*;

  localparam int RANDOM_BYTES   = 700;
  localparam int STEADY_FROM    = 560;
  localparam int PHASE_BYTES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  wbss_in_if  in_ch ();
  wbss_out_if out_ch ();

  wildcard_byte_stream_search dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  search_scoreboard sb;
  bit               steady;
  int unsigned      idle_cycles;
  int unsigned      bytes_sent;
  int unsigned      phases_run;
  int               stall_left;

  // Current settings, kept here so that streams can embed the pattern.
  logic [7:0]       pat [PAT_BYTES];
  logic [LEN_W-1:0] cur_len;
  bit               cur_fold;
  bit               cur_wild;
  bit               cur_words;

  always #10 clk_i = ~clk_i;

  // Check results and note accepted requests at each rising edge.
  always @(posedge clk_i) begin
    search_report_t got;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.match_found = out_ch.match_found;
        got.match_start = out_ch.match_start;
        got.lines_seen  = out_ch.lines_seen;
        got.line_start  = out_ch.line_start;
        got.no_match    = out_ch.no_match;
        sb.check_report(got);
      end
      if (in_ch.valid && in_ch.ready)
        sb.note_byte(in_ch.data_byte, in_ch.start_of_search, in_ch.end_of_data);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The result side stalls in random bursts, except in the steady part.
  always @(negedge clk_i) begin
    if (steady) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Nothing accepted for too long means the block hung.
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog expired after %0d cycles without a handshake", WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // One register write: a setup phase, then an access phase.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.note_config(idx, value);
  endtask

  // Write every register from the current settings; the block must be idle.
  task automatic apply_settings();
    logic [63:0] low;
    logic [63:0] high;
    for (int k = 0; k < 8; k++) begin
      low[8*k +: 8]  = pat[k];
      high[8*k +: 8] = pat[k+8];
    end
    write_reg(REG_PAT_LOW, low);
    write_reg(REG_PAT_HIGH, high);
    write_reg(REG_PAT_LEN, 64'(cur_len));
    write_reg(REG_IGN_CASE, 64'(cur_fold));
    write_reg(REG_WILDCARD, 64'(cur_wild));
    write_reg(REG_WHOLE_WORD, 64'(cur_words));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Send one byte request, with an occasional gap before it.
  task automatic send_byte(input logic [7:0] b, input bit sos, input bit eod);
    int gap;
    @(negedge clk_i);
    if (!steady && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.data_byte       <= b;
    in_ch.start_of_search <= sos;
    in_ch.end_of_data     <= eod;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Background bytes: half of them letters close to the pattern alphabet.
  function automatic logic [7:0] filler_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return "A" + 8'($urandom_range(0, 2));
      3, 4:    return "a" + 8'($urandom_range(0, 2));
      5:       return "0" + 8'($urandom_range(0, 1));
      6:       return "_";
      7:       return " ";
      8:       return NEWLINE_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pattern_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return "A" + 8'($urandom_range(0, 2));
      4:          return "0" + 8'($urandom_range(0, 1));
      5:          return WILDCARD_BYTE;
      6:          return " ";
      7:          return "_";
      8:          return NEWLINE_BYTE;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Pick new settings, the extremes among them, and write them.
  task automatic choose_settings();
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0:       cur_len = '0;
      1:       cur_len = LEN_W'($urandom_range(17, 31));
      2:       cur_len = LEN_W'(16);
      3:       cur_len = LEN_W'(1);
      default: cur_len = LEN_W'($urandom_range(1, 6));
    endcase
    foreach (pat[k]) begin
      if (mode == 4) pat[k] = 8'h00;
      else if (mode == 5) pat[k] = 8'hFF;
      else pat[k] = pattern_char();
    end
    cur_fold  = 1'($urandom_range(0, 1));
    cur_wild  = 1'($urandom_range(0, 1));
    cur_words = 1'($urandom_range(0, 1));
    apply_settings();
  endtask

  // A short stream that mostly carries copies of the pattern among filler.
  task automatic send_stream();
    logic [7:0] body[$];
    logic [7:0] b;
    int         want;
    int         eff;
    bit         sos;
    bit         eod;
    want = $urandom_range(1, 24);
    eff  = (cur_len > PAT_BYTES) ? PAT_BYTES : int'(cur_len);
    while (body.size() < want) begin
      if (eff > 0 && $urandom_range(0, 4) < 2) begin
        if (cur_words && $urandom_range(0, 1)) body.push_back(" ");
        for (int k = 0; k < eff; k++) begin
          b = pat[k];
          if (cur_wild && b == WILDCARD_BYTE) b = filler_byte();
          else if (cur_fold && b >= "A" && b <= "Z" && $urandom_range(0, 1)) b = b + 8'd32;
          body.push_back(b);
        end
        if (cur_words && $urandom_range(0, 1)) body.push_back(" ");
      end else begin
        body.push_back(filler_byte());
      end
    end
    foreach (body[i]) begin
      sos = (i == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 63) == 0);
      eod = (i == body.size() - 1) && ($urandom_range(0, 7) != 0);
      send_byte(body[i], sos, eod);
    end
  endtask

  initial begin
    int unsigned base;
    int unsigned phase_start;
    sb                    = new();
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_ch.valid           = 1'b0;
    in_ch.data_byte       = '0;
    in_ch.start_of_search = 1'b0;
    in_ch.end_of_data     = 1'b0;
    out_ch.ready          = 1'b0;
    steady                = 1'b0;
    idle_cycles           = 0;
    stall_left            = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: a one-byte pattern of zero, found after a newline.
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(NEWLINE_BYTE, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    drain();

    // Whole words with a wildcard and case folding: the first candidate is
    // spoiled by a word byte after it, the second is confirmed by a newline
    // that stays out of the line count.
    foreach (pat[k]) pat[k] = (k < 8) ? 8'h00 : 8'hFF;
    pat[0]    = "A";
    pat[1]    = WILDCARD_BYTE;
    pat[2]    = "C";
    cur_len   = LEN_W'(3);
    cur_fold  = 1'b1;
    cur_wild  = 1'b1;
    cur_words = 1'b1;
    apply_settings();
    send_byte("a", 1'b1, 1'b0);
    send_byte("x", 1'b0, 1'b0);
    send_byte("c", 1'b0, 1'b0);
    send_byte("_", 1'b0, 1'b0);
    send_byte(" ", 1'b0, 1'b0);
    send_byte("A", 1'b0, 1'b0);
    send_byte("?", 1'b0, 1'b0);
    send_byte("c", 1'b0, 1'b0);
    send_byte(NEWLINE_BYTE, 1'b0, 1'b0);
    drain();

    // A zero length never matches, so a single-byte stream ends empty.
    cur_len = '0;
    apply_settings();
    send_byte(8'h00, 1'b1, 1'b1);
    drain();

    // An oversized length acts as the longest pattern; end of data closes
    // the trailing word check.
    foreach (pat[k]) pat[k] = WILDCARD_BYTE;
    cur_len  = '1;
    cur_fold = 1'b0;
    apply_settings();
    for (int i = 0; i < PAT_BYTES; i++)
      send_byte(8'($urandom_range(0, 255)), i == 0, i == PAT_BYTES - 1);
    drain();
    for (int i = 0; i < PAT_BYTES; i++)
      send_byte(8'($urandom_range(0, 255)), i == 0, i == PAT_BYTES - 1);
    drain();

    // Random phases, each under fresh settings; the last part runs without stalls.
    base = bytes_sent;
    while (bytes_sent - base < RANDOM_BYTES) begin
      choose_settings();
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_stream();
      drain();
      phases_run++;
      steady = (bytes_sent - base >= STEADY_FROM);
    end

    repeat (8) @(posedge clk_i);
    $display("Sent %0d bytes (%0d scanned) over %0d random settings phases.",
             bytes_sent, sb.bytes_scanned, phases_run);
    $display("Checked %0d results: %0d matches, %0d streams ended without a match.",
             sb.reports_checked, sb.matches_seen, sb.misses_seen);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
